@@ rtl/fdmg_pkg.sv @@
// Package: shared types and constants of the frame difference motion gate.
`default_nettype none

package fdmg_pkg;

  localparam int FRAME_PIXELS = 307200;
  localparam int INDEX_W      = $clog2(FRAME_PIXELS + 1);
  localparam int ADDR_W       = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;

  localparam int CHAN_W       = 8;
  localparam int PIX_W        = 3 * CHAN_W;
  localparam int COUNT_W      = 19;
  localparam int FRAME_NUM_W  = 32;
  localparam int CFG_DATA_W   = 19;
  localparam int GRAY_SUM_W   = 22;
  localparam int GRAY_SHIFT   = 14;

  localparam logic [COUNT_W-1:0]    COUNT_MAX            = '1;
  localparam logic [CHAN_W-1:0]     DIFF_THRESHOLD_RESET = 8'd25;
  localparam logic [COUNT_W-1:0]    MAX_MOTION_RESET     = 19'd1000;

  localparam logic [GRAY_SUM_W-1:0] WEIGHT_BLUE  = 22'd1868;
  localparam logic [GRAY_SUM_W-1:0] WEIGHT_GREEN = 22'd9617;
  localparam logic [GRAY_SUM_W-1:0] WEIGHT_RED   = 22'd4899;
  localparam logic [GRAY_SUM_W-1:0] GRAY_ROUND   = 22'd8192;

  typedef enum logic [0:0] {
    REG_DIFF_THRESHOLD    = 1'b0,
    REG_MAX_MOTION_PIXELS = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
    logic              last_pixel;
  } pixel_t;

  typedef struct packed {
    logic                   send_frame;
    logic [COUNT_W-1:0]     motion_count;
    logic [FRAME_NUM_W-1:0] frame_number;
  } result_t;

  typedef struct packed {
    logic              last;
    logic              in_range;
    logic [ADDR_W-1:0] index;
    logic [PIX_W-1:0]  pix;
  } stage_t;

endpackage

`default_nettype wire

@@ rtl/fdmg_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module fdmg_ram #(
  parameter int DATA_W = 24,
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [DATA_W-1:0] wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output      logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/fdmg_gray.sv @@
// Gray level of the per-channel absolute difference between two BGR pixels.
`default_nettype none

module fdmg_gray
  import fdmg_pkg::*;
(
  input  wire logic [PIX_W-1:0]  cur_pix,
  input  wire logic [PIX_W-1:0]  base_pix,
  output      logic [CHAN_W-1:0] gray
);

  function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] x,
                                                 input logic [CHAN_W-1:0] y);
    abs_diff = (x > y) ? (x - y) : (y - x);
  endfunction

  logic [CHAN_W-1:0]     diff_b;
  logic [CHAN_W-1:0]     diff_g;
  logic [CHAN_W-1:0]     diff_r;
  logic [GRAY_SUM_W-1:0] sum;

  assign diff_b = abs_diff(cur_pix[CHAN_W-1:0], base_pix[CHAN_W-1:0]);
  assign diff_g = abs_diff(cur_pix[2*CHAN_W-1:CHAN_W], base_pix[2*CHAN_W-1:CHAN_W]);
  assign diff_r = abs_diff(cur_pix[3*CHAN_W-1:2*CHAN_W], base_pix[3*CHAN_W-1:2*CHAN_W]);

  assign sum = WEIGHT_BLUE  * GRAY_SUM_W'(diff_b)
             + WEIGHT_GREEN * GRAY_SUM_W'(diff_g)
             + WEIGHT_RED   * GRAY_SUM_W'(diff_r)
             + GRAY_ROUND;

  assign gray = sum[GRAY_SHIFT +: CHAN_W];

endmodule

`default_nettype wire

@@ rtl/frame_difference_motion_gate.sv @@
// Top level: frame difference motion gate over two ping-pong frame stores.
//
//   channel  | direction | handshake                  | beat
//   ---------+-----------+----------------------------+-------------------------------
//   pixel    | in        | pixel_valid / pixel_stall  | one BGR pixel, last_pixel flag
//   result   | out       | result_valid/result_stall  | one verdict per frame
//   cfg      | in        | cfg_write                  | one register write
//
// One pixel per cycle while pixel_stall is low; a result enters the output
// register once the last pixel of its frame has passed through s1 and s2.
// Both stores are read at accept, gray is formed against both in stage s1, the
// reference is picked and the pixel written back from stage s2, so a frame of
// one or two pixels holds the input while its write-back lands.
// Reset clears control state only; the stores are not cleared.
// A stalled result holds the pipeline only when a last-pixel beat reaches it.
`default_nettype none

module frame_difference_motion_gate
  import fdmg_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  pixel_valid,
  output      logic                  pixel_stall,
  input  wire pixel_t                pixel,
  output      logic                  result_valid,
  input  wire logic                  result_stall,
  output      result_t               result,
  input  wire logic                  cfg_write,
  input  wire cfg_reg_t              cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic [CHAN_W-1:0]      diff_threshold;
  logic [COUNT_W-1:0]     max_motion_pixels;

  logic [INDEX_W-1:0]     pixel_index;
  logic [1:0]             gap;
  logic                   ref_sel;
  logic                   have_ref;
  logic [COUNT_W-1:0]     running_count;
  logic [FRAME_NUM_W-1:0] next_frame_number;

  logic                   s1_valid;
  stage_t                 s1;
  logic                   s2_valid;
  stage_t                 s2;
  logic [CHAN_W-1:0]      s2_gray_a;
  logic [CHAN_W-1:0]      s2_gray_b;

  logic                   hold;
  logic                   adv;
  logic                   accept;
  logic                   in_range;
  logic                   rd_en;
  logic [ADDR_W-1:0]      rd_addr;
  logic [PIX_W-1:0]       cur_pix;
  logic [PIX_W-1:0]       rd_data_a;
  logic [PIX_W-1:0]       rd_data_b;
  logic [CHAN_W-1:0]      gray_a;
  logic [CHAN_W-1:0]      gray_b;
  logic                   retire;
  logic                   wr_en_a;
  logic                   wr_en_b;
  logic [CHAN_W-1:0]      ref_gray;
  logic                   motion;
  logic [COUNT_W-1:0]     count_next;
  logic [COUNT_W-1:0]     frame_count;
  logic                   send;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      diff_threshold    <= DIFF_THRESHOLD_RESET;
      max_motion_pixels <= MAX_MOTION_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_DIFF_THRESHOLD:    diff_threshold    <= cfg_data[CHAN_W-1:0];
        REG_MAX_MOTION_PIXELS: max_motion_pixels <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // input side
  assign hold        = s2_valid && s2.last && result_valid && result_stall;
  assign adv         = !hold;
  assign pixel_stall = hold || (gap != 2'd0);
  assign accept      = pixel_valid && !pixel_stall;
  assign in_range    = (pixel_index != INDEX_W'(FRAME_PIXELS));
  assign rd_en       = accept && in_range;
  assign rd_addr     = pixel_index[ADDR_W-1:0];
  assign cur_pix     = {pixel.red, pixel.green, pixel.blue};

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_index <= '0;
      gap         <= 2'd0;
    end else begin
      if (accept) begin
        if (pixel.last_pixel) begin
          pixel_index <= '0;
        end else if (in_range) begin
          pixel_index <= pixel_index + INDEX_W'(1);
        end
      end
      if (accept && pixel.last_pixel && (pixel_index <= INDEX_W'(1))) begin
        gap <= 2'd2;
      end else if (adv && (gap != 2'd0)) begin
        gap <= gap - 2'd1;
      end
    end
  end

  // frame stores
  fdmg_ram #(
    .DATA_W (PIX_W),
    .DEPTH  (FRAME_PIXELS),
    .ADDR_W (ADDR_W)
  ) u_store_a (
    .clk     (clk),
    .wr_en   (wr_en_a),
    .wr_addr (s2.index),
    .wr_data (s2.pix),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data_a)
  );

  fdmg_ram #(
    .DATA_W (PIX_W),
    .DEPTH  (FRAME_PIXELS),
    .ADDR_W (ADDR_W)
  ) u_store_b (
    .clk     (clk),
    .wr_en   (wr_en_b),
    .wr_addr (s2.index),
    .wr_data (s2.pix),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data_b)
  );

  fdmg_gray u_gray_a (
    .cur_pix  (s1.pix),
    .base_pix (rd_data_a),
    .gray     (gray_a)
  );

  fdmg_gray u_gray_b (
    .cur_pix  (s1.pix),
    .base_pix (rd_data_b),
    .gray     (gray_b)
  );

  // pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= accept;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1.last     <= pixel.last_pixel;
      s1.in_range <= in_range;
      s1.index    <= rd_addr;
      s1.pix      <= cur_pix;
      s2          <= s1;
      s2_gray_a   <= gray_a;
      s2_gray_b   <= gray_b;
    end
  end

  // compare, count, write back
  assign retire      = adv && s2_valid;
  assign wr_en_a     = retire && s2.in_range && ref_sel;
  assign wr_en_b     = retire && s2.in_range && !ref_sel;
  assign ref_gray    = ref_sel ? s2_gray_b : s2_gray_a;
  assign motion      = have_ref && s2.in_range && (ref_gray > diff_threshold) &&
                       (running_count != COUNT_MAX);
  assign count_next  = running_count + COUNT_W'(motion);
  assign frame_count = have_ref ? count_next : '0;
  assign send        = !have_ref || (frame_count > max_motion_pixels);

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_sel           <= 1'b0;
      have_ref          <= 1'b0;
      running_count     <= '0;
      next_frame_number <= '0;
    end else if (retire) begin
      if (s2.last) begin
        running_count <= '0;
        if (send) begin
          next_frame_number <= next_frame_number + FRAME_NUM_W'(1);
          ref_sel           <= !ref_sel;
          have_ref          <= 1'b1;
        end
      end else begin
        running_count <= count_next;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (retire && s2.last) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (retire && s2.last) begin
      result.send_frame   <= send;
      result.motion_count <= frame_count;
      result.frame_number <= send ? next_frame_number : '0;
    end
  end

  a_no_same_entry_rw: assert property (@(posedge clk) disable iff (rst)
    (wr_en_a || wr_en_b) && rd_en |-> s2.index != rd_addr)
    else $error("frame store read and write hit the same entry");

  a_swap_on_send: assert property (@(posedge clk) disable iff (rst)
    retire && s2.last && send |=> (ref_sel != $past(ref_sel)) && have_ref)
    else $error("reference not swapped after a sent frame");

  a_frame_end: assert property (@(posedge clk) disable iff (rst)
    retire && s2.last |=> result_valid && (running_count == '0))
    else $error("frame end did not load result or clear count");

  a_no_count_without_ref: assert property (@(posedge clk) disable iff (rst)
    !have_ref |-> running_count == '0)
    else $error("motion counted before a reference frame exists");

endmodule

`default_nettype wire
